>>> design/gpad_pkg.sv
`timescale 1ns / 1ps

package gpad_pkg;

    // Event classes
    localparam logic [4:0] EV_SYN = 5'd0;
    localparam logic [4:0] EV_KEY = 5'd1;
    localparam logic [4:0] EV_ABS = 5'd3;

    // Sync codes
    localparam logic [9:0] SYN_REPORT  = 10'h000;
    localparam logic [9:0] SYN_DROPPED = 10'h003;

    // Button codes
    localparam logic [9:0] PAD_FACE_DOWN  = 10'h130;
    localparam logic [9:0] PAD_FACE_RIGHT = 10'h131;
    localparam logic [9:0] PAD_FACE_UP    = 10'h133;
    localparam logic [9:0] PAD_FACE_LEFT  = 10'h134;
    localparam logic [9:0] PAD_BUMPER_L   = 10'h136;
    localparam logic [9:0] PAD_BUMPER_R   = 10'h137;
    localparam logic [9:0] PAD_VIEW       = 10'h13A;
    localparam logic [9:0] PAD_MENU       = 10'h13B;
    localparam logic [9:0] PAD_GUIDE      = 10'h13C;
    localparam logic [9:0] PAD_STICK_L    = 10'h13D;
    localparam logic [9:0] PAD_STICK_R    = 10'h13E;

    // Absolute axis codes
    localparam logic [9:0] AXC_LEFT_X  = 10'h000;
    localparam logic [9:0] AXC_LEFT_Y  = 10'h001;
    localparam logic [9:0] AXC_RIGHT_X = 10'h002;
    localparam logic [9:0] AXC_RIGHT_Y = 10'h005;
    localparam logic [9:0] AXC_TRIG_R  = 10'h009;
    localparam logic [9:0] AXC_TRIG_L  = 10'h00A;
    localparam logic [9:0] AXC_HAT_X   = 10'h010;
    localparam logic [9:0] AXC_HAT_Y   = 10'h011;

    // Hat component codes
    localparam logic [1:0] HAT_ZERO  = 2'd0;
    localparam logic [1:0] HAT_PLUS  = 2'd1;
    localparam logic [1:0] HAT_OTHER = 2'd2;
    localparam logic [1:0] HAT_MINUS = 2'd3;

    localparam logic [7:0]  DEAD_ZONE_RESET = 8'd18;
    localparam logic [15:0] STICK_CENTER    = 16'h8000;

    typedef struct packed {
        logic [4:0]         event_type;
        logic [9:0]         event_code;
        logic signed [31:0] event_value;
    } event_t;

    typedef struct packed {
        logic [15:0] left_x;
        logic [15:0] left_y;
        logic [15:0] right_x;
        logic [15:0] right_y;
        logic [9:0]  left_trigger;
        logic [9:0]  right_trigger;
        logic [3:0]  hat_direction;
        logic [7:0]  buttons_low;
        logic [6:0]  buttons_high;
    } report_t;

    typedef enum logic [2:0] {
        AXIS_NONE,
        AXIS_STICK,
        AXIS_TRIGGER,
        AXIS_HAT_X,
        AXIS_HAT_Y
    } axis_t;

    // Decoded form of one event, handed from the input stage to the state update.
    typedef struct packed {
        logic       emit;
        logic       clear;
        logic       key_hit;
        logic       key_on;
        logic       key_high;
        logic [2:0] key_bit;
        axis_t      axis;
        logic [1:0] stick_idx;
        logic       trig_idx;
        logic [7:0] sample;
        logic [1:0] hat_code;
    } cmd_t;

endpackage

>>> design/gpad_in_stage.sv
`timescale 1ns / 1ps

module gpad_in_stage
    import gpad_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   event_valid,
    output logic   event_ready,
    input  event_t event_data,
    input  logic   advance,
    output logic   cmd_valid,
    output cmd_t   cmd
);

    logic   valid_reg;
    logic   valid_next;
    event_t event_reg;

    assign event_ready = !valid_reg || advance;
    assign valid_next  = event_valid || (valid_reg && !advance);
    assign cmd_valid   = valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            if (event_ready)
            begin
                valid_reg <= valid_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (event_valid && event_ready)
        begin
            event_reg <= event_data;
        end
    end

    always_comb
    begin
        cmd           = '0;
        cmd.axis      = AXIS_NONE;
        cmd.sample    = event_reg.event_value[7:0];
        cmd.key_on    = (event_reg.event_value == 32'sd1);

        // The hat compares the full value, so large values fall to the other code.
        if (event_reg.event_value == 32'sd0)
        begin
            cmd.hat_code = HAT_ZERO;
        end
        else if (event_reg.event_value == 32'sd1)
        begin
            cmd.hat_code = HAT_PLUS;
        end
        else if (event_reg.event_value == -32'sd1)
        begin
            cmd.hat_code = HAT_MINUS;
        end
        else
        begin
            cmd.hat_code = HAT_OTHER;
        end

        case (event_reg.event_type)
            EV_KEY:
            begin
                cmd.emit    = 1'b1;
                cmd.key_hit = 1'b1;
                case (event_reg.event_code)
                    PAD_FACE_DOWN:  cmd.key_bit = 3'd1;
                    PAD_FACE_RIGHT: cmd.key_bit = 3'd0;
                    PAD_FACE_UP:    cmd.key_bit = 3'd3;
                    PAD_FACE_LEFT:  cmd.key_bit = 3'd4;
                    PAD_BUMPER_L:   cmd.key_bit = 3'd6;
                    PAD_BUMPER_R:   cmd.key_bit = 3'd7;
                    PAD_VIEW:
                    begin
                        cmd.key_high = 1'b1;
                        cmd.key_bit  = 3'd2;
                    end
                    PAD_MENU:
                    begin
                        cmd.key_high = 1'b1;
                        cmd.key_bit  = 3'd3;
                    end
                    PAD_GUIDE:
                    begin
                        cmd.key_high = 1'b1;
                        cmd.key_bit  = 3'd4;
                    end
                    PAD_STICK_L:
                    begin
                        cmd.key_high = 1'b1;
                        cmd.key_bit  = 3'd5;
                    end
                    PAD_STICK_R:
                    begin
                        cmd.key_high = 1'b1;
                        cmd.key_bit  = 3'd6;
                    end
                    default:        cmd.key_hit = 1'b0;
                endcase
            end
            EV_ABS:
            begin
                case (event_reg.event_code)
                    AXC_LEFT_X:
                    begin
                        cmd.axis      = AXIS_STICK;
                        cmd.stick_idx = 2'd0;
                    end
                    AXC_LEFT_Y:
                    begin
                        cmd.axis      = AXIS_STICK;
                        cmd.stick_idx = 2'd1;
                    end
                    AXC_RIGHT_X:
                    begin
                        cmd.axis      = AXIS_STICK;
                        cmd.stick_idx = 2'd2;
                    end
                    AXC_RIGHT_Y:
                    begin
                        cmd.axis      = AXIS_STICK;
                        cmd.stick_idx = 2'd3;
                    end
                    AXC_TRIG_R:
                    begin
                        cmd.axis     = AXIS_TRIGGER;
                        cmd.trig_idx = 1'b1;
                    end
                    AXC_TRIG_L:
                    begin
                        cmd.axis     = AXIS_TRIGGER;
                        cmd.trig_idx = 1'b0;
                    end
                    AXC_HAT_X:  cmd.axis = AXIS_HAT_X;
                    AXC_HAT_Y:  cmd.axis = AXIS_HAT_Y;
                    default:    cmd.axis = AXIS_NONE;
                endcase
            end
            EV_SYN:
            begin
                case (event_reg.event_code)
                    SYN_REPORT:  cmd.emit = 1'b1;
                    SYN_DROPPED:
                    begin
                        cmd.emit  = 1'b1;
                        cmd.clear = 1'b1;
                    end
                    default:     cmd.emit = 1'b0;
                endcase
            end
            default:
            begin
                cmd.emit = 1'b0;
            end
        endcase
    end

endmodule

>>> design/gpad_state.sv
`timescale 1ns / 1ps

module gpad_state
    import gpad_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_write_en,
    input  logic [7:0] cfg_write_data,
    input  logic       advance,
    input  cmd_t       cmd,
    output report_t    report_next
);

    logic [7:0]  dead_zone_reg;
    logic [15:0] stick_reg [4];
    logic [15:0] stick_next [4];
    logic [9:0]  trig_reg [2];
    logic [9:0]  trig_next [2];
    logic [1:0]  hat_x_reg;
    logic [1:0]  hat_x_next;
    logic [1:0]  hat_y_reg;
    logic [1:0]  hat_y_next;
    logic [7:0]  btn_low_reg;
    logic [7:0]  btn_low_next;
    logic [6:0]  btn_high_reg;
    logic [6:0]  btn_high_next;

    logic signed [9:0] recentred;
    logic signed [9:0] dz_signed;
    logic              in_dead_zone;
    logic [15:0]       stick_value;
    logic [1:0]        trig_frac;
    logic [9:0]        trig_value;

    function automatic logic [3:0] hat_dir(input logic [1:0] x, input logic [1:0] y);
        logic [3:0] dir;
        dir = 4'd0;
        if (x == HAT_ZERO && y == HAT_MINUS) dir = 4'd1;
        if (x == HAT_PLUS && y == HAT_MINUS) dir = 4'd2;
        if (x == HAT_PLUS && y == HAT_ZERO) dir = 4'd3;
        if (x == HAT_PLUS && y == HAT_PLUS) dir = 4'd4;
        if (x == HAT_ZERO && y == HAT_PLUS) dir = 4'd5;
        if (x == HAT_MINUS && y == HAT_PLUS) dir = 4'd6;
        if (x == HAT_MINUS && y == HAT_ZERO) dir = 4'd7;
        if (x == HAT_MINUS && y == HAT_MINUS) dir = 4'd8;
        return dir;
    endfunction

    // Recentred sample s = byte - 128 becomes byte * 256 outside the dead zone,
    // which is exactly s * 256 + 0x8000.
    assign recentred    = $signed({2'b00, cmd.sample}) - 10'sd128;
    assign dz_signed    = $signed({2'b00, dead_zone_reg});
    assign in_dead_zone = (recentred > -dz_signed) && (recentred < dz_signed);
    assign stick_value  = in_dead_zone ? STICK_CENTER : {cmd.sample, 8'h00};

    // byte * 1023 / 255 equals 4 * byte plus byte / 85, which is at most 3.
    always_comb
    begin
        if (cmd.sample == 8'd255)
        begin
            trig_frac = 2'd3;
        end
        else if (cmd.sample >= 8'd170)
        begin
            trig_frac = 2'd2;
        end
        else if (cmd.sample >= 8'd85)
        begin
            trig_frac = 2'd1;
        end
        else
        begin
            trig_frac = 2'd0;
        end
    end

    assign trig_value = {cmd.sample, 2'b00} + {8'd0, trig_frac};

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            stick_next[i] = stick_reg[i];
        end
        for (int i = 0; i < 2; i++)
        begin
            trig_next[i] = trig_reg[i];
        end
        hat_x_next    = hat_x_reg;
        hat_y_next    = hat_y_reg;
        btn_low_next  = btn_low_reg;
        btn_high_next = btn_high_reg;

        if (cmd.clear)
        begin
            for (int i = 0; i < 4; i++)
            begin
                stick_next[i] = STICK_CENTER;
            end
            for (int i = 0; i < 2; i++)
            begin
                trig_next[i] = '0;
            end
            hat_x_next    = HAT_ZERO;
            hat_y_next    = HAT_ZERO;
            btn_low_next  = '0;
            btn_high_next = '0;
        end
        else if (cmd.key_hit)
        begin
            if (cmd.key_high)
            begin
                btn_high_next[cmd.key_bit] = cmd.key_on;
            end
            else
            begin
                btn_low_next[cmd.key_bit] = cmd.key_on;
            end
        end
        else
        begin
            case (cmd.axis)
                AXIS_STICK:   stick_next[cmd.stick_idx] = stick_value;
                AXIS_TRIGGER: trig_next[cmd.trig_idx]   = trig_value;
                AXIS_HAT_X:   hat_x_next                = cmd.hat_code;
                AXIS_HAT_Y:   hat_y_next                = cmd.hat_code;
                default:      hat_x_next                = hat_x_reg;
            endcase
        end
    end

    always_comb
    begin
        report_next.left_x        = stick_next[0];
        report_next.left_y        = stick_next[1];
        report_next.right_x       = stick_next[2];
        report_next.right_y       = stick_next[3];
        report_next.left_trigger  = trig_next[0];
        report_next.right_trigger = trig_next[1];
        report_next.hat_direction = hat_dir(hat_x_next, hat_y_next);
        report_next.buttons_low   = btn_low_next;
        report_next.buttons_high  = btn_high_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dead_zone_reg <= DEAD_ZONE_RESET;
        end
        else
        begin
            if (cfg_write_en)
            begin
                dead_zone_reg <= cfg_write_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
            begin
                stick_reg[i] <= STICK_CENTER;
            end
            for (int i = 0; i < 2; i++)
            begin
                trig_reg[i] <= '0;
            end
            hat_x_reg    <= HAT_ZERO;
            hat_y_reg    <= HAT_ZERO;
            btn_low_reg  <= '0;
            btn_high_reg <= '0;
        end
        else
        begin
            if (advance)
            begin
                for (int i = 0; i < 4; i++)
                begin
                    stick_reg[i] <= stick_next[i];
                end
                for (int i = 0; i < 2; i++)
                begin
                    trig_reg[i] <= trig_next[i];
                end
                hat_x_reg    <= hat_x_next;
                hat_y_reg    <= hat_y_next;
                btn_low_reg  <= btn_low_next;
                btn_high_reg <= btn_high_next;
            end
        end
    end

endmodule

>>> design/gpad_out_stage.sv
`timescale 1ns / 1ps

module gpad_out_stage
    import gpad_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  report_t load_data,
    output logic    free,
    output logic    report_valid,
    input  logic    report_ready,
    output report_t report_data
);

    logic    valid_reg;
    report_t data_reg;

    // The slot counts as free in the same cycle that its request is taken.
    assign free         = !valid_reg || report_ready;
    assign report_valid = valid_reg;
    assign report_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                valid_reg <= 1'b1;
            end
            else if (report_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= load_data;
        end
    end

endmodule

>>> design/gamepad_event_to_hid_report.sv
`timescale 1ns / 1ps

// Converts input events (type, code, value) into gamepad HID report requests.
// An event is registered on entry, decoded and applied to the report state once
// it can advance, and a key event, sync-report or sync-dropped loads the
// updated report into the output register. One event is taken per clock; the
// only thing that holds the input back is a report that waits at the output
// while the next event also wants to emit one. An accepted event passes the
// input register and then, when it advances, the output register, which raises
// the report request. The dead zone register is written with cfg_write_en and
// takes effect on the next event.

module gamepad_event_to_hid_report
    import gpad_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_write_en,
    input  logic [7:0] cfg_write_data,
    input  logic       event_valid,
    output logic       event_ready,
    input  event_t     event_data,
    output logic       report_valid,
    input  logic       report_ready,
    output report_t    report_data
);

    logic    cmd_valid;
    cmd_t    cmd;
    logic    out_free;
    logic    advance;
    report_t report_next;

    // A decoded event moves on unless it needs the output slot and the slot is taken.
    assign advance = cmd_valid && (!cmd.emit || out_free);

    gpad_in_stage u_in_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .event_valid (event_valid),
        .event_ready (event_ready),
        .event_data  (event_data),
        .advance     (advance),
        .cmd_valid   (cmd_valid),
        .cmd         (cmd)
    );

    gpad_state u_state (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .advance        (advance),
        .cmd            (cmd),
        .report_next    (report_next)
    );

    gpad_out_stage u_out_stage (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (advance && cmd.emit),
        .load_data    (report_next),
        .free         (out_free),
        .report_valid (report_valid),
        .report_ready (report_ready),
        .report_data  (report_data)
    );

    // A held report must not be overwritten by a new one.
    assert property (@(posedge clk) disable iff (!rst_n)
        report_valid && !report_ready |=> $stable(report_data))
        else $error("pending report request was overwritten");

    // Sync-dropped always yields a neutral report.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && cmd.clear |=> report_valid && report_data.left_x == STICK_CENTER
            && report_data.right_y == STICK_CENTER && report_data.buttons_low == 8'd0
            && report_data.hat_direction == 4'd0 && report_data.left_trigger == 10'd0)
        else $error("sync-dropped report is not neutral");

    // Unmapped button positions never light up.
    assert property (@(posedge clk) disable iff (!rst_n)
        report_valid |-> report_data.buttons_low[2] == 1'b0
            && report_data.buttons_low[5] == 1'b0 && report_data.buttons_high[1:0] == 2'b00)
        else $error("unmapped button bit set in report");

    // The hat field stays within its nine codes.
    assert property (@(posedge clk) disable iff (!rst_n)
        report_valid |-> report_data.hat_direction <= 4'd8)
        else $error("hat direction out of range");

    // A decoded event that cannot move on is kept for the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !advance |=> cmd_valid && !event_ready == !report_ready)
        else $error("stalled event was lost");

endmodule

>>> bench/gamepad_event_to_hid_report_test.sv
`timescale 1ns / 1ps

module gamepad_event_to_hid_report_test;
    import gpad_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_CYCLES = 6;
    localparam int PHASE_ITEMS = 285;

    // Bit positions inside the two button bytes of the report.
    localparam int BIT_A = 0;
    localparam int BIT_B = 1;
    localparam int BIT_X = 3;
    localparam int BIT_Y = 4;
    localparam int BIT_LB = 6;
    localparam int BIT_RB = 7;
    localparam int BIT_VIEW = 2;
    localparam int BIT_MENU = 3;
    localparam int BIT_GUIDE = 4;
    localparam int BIT_LS = 5;
    localparam int BIT_RS = 6;

    // Hat field values, clockwise from up.
    localparam logic [3:0] DIR_CENTER = 4'd0;
    localparam logic [3:0] DIR_N = 4'd1;
    localparam logic [3:0] DIR_NE = 4'd2;
    localparam logic [3:0] DIR_E = 4'd3;
    localparam logic [3:0] DIR_SE = 4'd4;
    localparam logic [3:0] DIR_S = 4'd5;
    localparam logic [3:0] DIR_SW = 4'd6;
    localparam logic [3:0] DIR_W = 4'd7;
    localparam logic [3:0] DIR_NW = 4'd8;

    localparam logic [10:0][9:0] BUTTON_CODES = {
        PAD_STICK_R, PAD_STICK_L, PAD_GUIDE, PAD_MENU, PAD_VIEW, PAD_BUMPER_R,
        PAD_BUMPER_L, PAD_FACE_LEFT, PAD_FACE_UP, PAD_FACE_RIGHT, PAD_FACE_DOWN
    };
    localparam logic [7:0][9:0] AXIS_CODES = {
        AXC_HAT_Y, AXC_HAT_X, AXC_TRIG_L, AXC_TRIG_R, AXC_RIGHT_Y, AXC_RIGHT_X,
        AXC_LEFT_Y, AXC_LEFT_X
    };

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_write_en;
    logic [7:0] cfg_write_data;
    logic event_valid;
    logic event_ready;
    event_t event_data;
    logic report_valid;
    logic report_ready;
    report_t report_data;

    // Model of the report state as the block should hold it.
    logic [15:0] sticks [0:3];
    logic [9:0] triggers [0:1];
    logic [1:0] hat_h;
    logic [1:0] hat_v;
    logic [7:0] buttons_lo;
    logic [6:0] buttons_hi;
    logic [7:0] dead_zone;

    // Reports the block still owes, oldest first.
    report_t pending_reports [$];
    report_t want;

    int mismatch_count = 0;
    int cycle_count = 0;
    logic sender_steady;
    logic receiver_steady;

    gamepad_event_to_hid_report uut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_write_en(cfg_write_en),
        .cfg_write_data(cfg_write_data),
        .event_valid(event_valid),
        .event_ready(event_ready),
        .event_data(event_data),
        .report_valid(report_valid),
        .report_ready(report_ready),
        .report_data(report_data)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("gamepad_event_to_hid_report regression: fail");
            $finish;
        end
    end

    function automatic logic [15:0] stick_level(input logic [7:0] sample);
        int offset;
        int dz;
        int level;
        offset = int'(sample) - 128;
        dz = int'(dead_zone);
        if (offset > -dz && offset < dz)
            offset = 0;
        level = offset * 256 + 32768;
        return level[15:0];
    endfunction

    function automatic logic [9:0] trigger_level(input logic [7:0] sample);
        int scaled;
        scaled = (int'(sample) * 1023) / 255;
        return scaled[9:0];
    endfunction

    function automatic logic [1:0] hat_state(input logic signed [31:0] value);
        if (value == 32'sd0)
            return HAT_ZERO;
        if (value == 32'sd1)
            return HAT_PLUS;
        if (value == -32'sd1)
            return HAT_MINUS;
        return HAT_OTHER;
    endfunction

    function automatic void clear_report_state();
        for (int i = 0; i < 4; i++)
            sticks[i] = STICK_CENTER;
        triggers[0] = '0;
        triggers[1] = '0;
        hat_h = HAT_ZERO;
        hat_v = HAT_ZERO;
        buttons_lo = '0;
        buttons_hi = '0;
    endfunction

    // Applies one accepted event to the report state and queues the report it causes.
    function automatic void apply_event(input event_t ev);
        logic on;
        logic emit;
        report_t rep;
        on = (ev.event_value == 32'sd1);
        emit = 1'b0;
        case (ev.event_type)
            EV_KEY:
            begin
                emit = 1'b1;
                case (ev.event_code)
                    PAD_FACE_DOWN: buttons_lo[BIT_B] = on;
                    PAD_FACE_RIGHT: buttons_lo[BIT_A] = on;
                    PAD_FACE_UP: buttons_lo[BIT_X] = on;
                    PAD_FACE_LEFT: buttons_lo[BIT_Y] = on;
                    PAD_BUMPER_L: buttons_lo[BIT_LB] = on;
                    PAD_BUMPER_R: buttons_lo[BIT_RB] = on;
                    PAD_VIEW: buttons_hi[BIT_VIEW] = on;
                    PAD_MENU: buttons_hi[BIT_MENU] = on;
                    PAD_GUIDE: buttons_hi[BIT_GUIDE] = on;
                    PAD_STICK_L: buttons_hi[BIT_LS] = on;
                    PAD_STICK_R: buttons_hi[BIT_RS] = on;
                    default: ;
                endcase
            end
            EV_ABS:
            begin
                case (ev.event_code)
                    AXC_LEFT_X: sticks[0] = stick_level(ev.event_value[7:0]);
                    AXC_LEFT_Y: sticks[1] = stick_level(ev.event_value[7:0]);
                    AXC_RIGHT_X: sticks[2] = stick_level(ev.event_value[7:0]);
                    AXC_RIGHT_Y: sticks[3] = stick_level(ev.event_value[7:0]);
                    AXC_TRIG_R: triggers[1] = trigger_level(ev.event_value[7:0]);
                    AXC_TRIG_L: triggers[0] = trigger_level(ev.event_value[7:0]);
                    AXC_HAT_X: hat_h = hat_state(ev.event_value);
                    AXC_HAT_Y: hat_v = hat_state(ev.event_value);
                    default: ;
                endcase
            end
            EV_SYN:
            begin
                if (ev.event_code == SYN_REPORT)
                    emit = 1'b1;
                else if (ev.event_code == SYN_DROPPED)
                begin
                    clear_report_state();
                    emit = 1'b1;
                end
            end
            default: ;
        endcase
        if (emit)
        begin
            rep.left_x = sticks[0];
            rep.left_y = sticks[1];
            rep.right_x = sticks[2];
            rep.right_y = sticks[3];
            rep.left_trigger = triggers[0];
            rep.right_trigger = triggers[1];
            case ({hat_h, hat_v})
                {HAT_ZERO, HAT_MINUS}: rep.hat_direction = DIR_N;
                {HAT_PLUS, HAT_MINUS}: rep.hat_direction = DIR_NE;
                {HAT_PLUS, HAT_ZERO}: rep.hat_direction = DIR_E;
                {HAT_PLUS, HAT_PLUS}: rep.hat_direction = DIR_SE;
                {HAT_ZERO, HAT_PLUS}: rep.hat_direction = DIR_S;
                {HAT_MINUS, HAT_PLUS}: rep.hat_direction = DIR_SW;
                {HAT_MINUS, HAT_ZERO}: rep.hat_direction = DIR_W;
                {HAT_MINUS, HAT_MINUS}: rep.hat_direction = DIR_NW;
                default: rep.hat_direction = DIR_CENTER;
            endcase
            rep.buttons_low = buttons_lo;
            rep.buttons_high = buttons_hi;
            pending_reports.push_back(rep);
        end
    endfunction

    // Report side: unless set steady, stalls a random number of cycles before taking each request.
    initial
    begin
        int hold;
        report_ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            hold = receiver_steady ? 0 : $urandom_range(0, 6);
            if (hold > 0)
            begin
                report_ready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            report_ready <= 1'b1;
            @(posedge clk);
            while (!report_valid)
                @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (report_valid && report_ready)
        begin
            if (pending_reports.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected report request at cycle %0d: %h",
                             cycle_count, report_data);
            end
            else
            begin
                want = pending_reports.pop_front();
                if (want.left_x !== report_data.left_x
                    || want.left_y !== report_data.left_y
                    || want.right_x !== report_data.right_x
                    || want.right_y !== report_data.right_y
                    || want.left_trigger !== report_data.left_trigger
                    || want.right_trigger !== report_data.right_trigger
                    || want.hat_direction !== report_data.hat_direction
                    || want.buttons_low !== report_data.buttons_low
                    || want.buttons_high !== report_data.buttons_high)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                    begin
                        $display("report mismatch at cycle %0d", cycle_count);
                        $display("  expected lx %h ly %h rx %h ry %h lt %h rt %h hat %0d lo %h hi %h",
                                 want.left_x, want.left_y, want.right_x, want.right_y,
                                 want.left_trigger, want.right_trigger,
                                 want.hat_direction, want.buttons_low, want.buttons_high);
                        $display("  actual   lx %h ly %h rx %h ry %h lt %h rt %h hat %0d lo %h hi %h",
                                 report_data.left_x, report_data.left_y,
                                 report_data.right_x, report_data.right_y,
                                 report_data.left_trigger, report_data.right_trigger,
                                 report_data.hat_direction, report_data.buttons_low,
                                 report_data.buttons_high);
                    end
                end
            end
        end
    end

    // Holds valid until the request is taken. Valid is left high on return so that
    // a following request with no gap does not drop it for a step.
    task automatic deliver_event(input event_t ev);
        int gap;
        gap = sender_steady ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            event_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        event_valid <= 1'b1;
        event_data <= ev;
        @(posedge clk);
        while (!event_ready)
            @(posedge clk);
        apply_event(ev);
    endtask

    task automatic send_event(input logic [4:0] kind, input logic [9:0] code,
                              input logic [31:0] value);
        event_t ev;
        ev.event_type = kind;
        ev.event_code = code;
        ev.event_value = value;
        deliver_event(ev);
    endtask

    // Axis events cause no report, so the block may still be busy after the last
    // report arrives; the SETTLE_CYCLES wait that follows covers its pipeline.
    task automatic drain_reports();
        event_valid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_dead_zone(input logic [7:0] value);
        cfg_write_en <= 1'b1;
        cfg_write_data <= value;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        dead_zone = value;
    endtask

    function automatic event_t pick_event();
        event_t ev;
        int roll;
        int near;
        logic [31:0] raw;
        roll = $urandom_range(0, 99);
        raw = $urandom;
        ev.event_value = raw;
        if (roll < 35)
        begin
            ev.event_type = EV_KEY;
            if ($urandom_range(0, 4) == 0)
                ev.event_code = 10'($urandom_range(0, 1023));
            else
                ev.event_code = BUTTON_CODES[$urandom_range(0, 10)];
            case ($urandom_range(0, 5))
                0, 1: ev.event_value = 32'sd1;
                2, 3: ev.event_value = 32'sd0;
                4: ev.event_value = 32'sd2;
                default: ;
            endcase
        end
        else if (roll < 75)
        begin
            ev.event_type = EV_ABS;
            if ($urandom_range(0, 7) == 0)
                ev.event_code = 10'($urandom_range(0, 1023));
            else
                ev.event_code = AXIS_CODES[$urandom_range(0, 7)];
            if (ev.event_code == AXC_HAT_X || ev.event_code == AXC_HAT_Y)
            begin
                if ($urandom_range(0, 4) != 0)
                    ev.event_value = $urandom_range(0, 2) - 1;
            end
            else if ($urandom_range(0, 2) == 0)
            begin
                // Aim at the edges of the dead zone, where off-by-one errors live.
                near = 128 + ($urandom_range(0, 1) ? int'(dead_zone) : -int'(dead_zone))
                       + $urandom_range(0, 2) - 1;
                raw[7:0] = near[7:0];
                ev.event_value = raw;
            end
        end
        else if (roll < 92)
        begin
            ev.event_type = EV_SYN;
            case ($urandom_range(0, 9))
                7: ev.event_code = SYN_DROPPED;
                8, 9: ev.event_code = 10'($urandom_range(0, 1023));
                default: ev.event_code = SYN_REPORT;
            endcase
        end
        else
        begin
            ev.event_type = 5'($urandom_range(0, 31));
            ev.event_code = 10'($urandom_range(0, 1023));
        end
        return ev;
    endfunction

    task automatic test_idle_report();
        send_event(EV_SYN, SYN_REPORT, 32'd0);
    endtask

    task automatic test_buttons();
        for (int i = 0; i < 11; i++)
            send_event(EV_KEY, BUTTON_CODES[i], 32'd1);
        // Autorepeat and any value other than one release the button.
        send_event(EV_KEY, PAD_FACE_DOWN, 32'd2);
        send_event(EV_KEY, PAD_FACE_RIGHT, 32'h8000_0000);
        send_event(EV_KEY, 10'h3FF, 32'd1);
    endtask

    task automatic test_axes();
        send_event(EV_ABS, AXC_LEFT_X, 32'h7FFF_FFFF);
        send_event(EV_ABS, AXC_LEFT_Y, 32'h8000_0000);
        send_event(EV_ABS, AXC_RIGHT_X, 32'd145);
        send_event(EV_ABS, AXC_RIGHT_Y, 32'd110);
        send_event(EV_ABS, AXC_TRIG_R, 32'd255);
        send_event(EV_ABS, AXC_TRIG_L, 32'h0000_0180);
        send_event(EV_ABS, AXC_HAT_X, 32'hFFFF_FFFF);
        send_event(EV_ABS, AXC_HAT_Y, 32'd1);
        send_event(EV_SYN, SYN_REPORT, 32'd0);
        // A hat component outside -1..1 centres the hat while it is held.
        send_event(EV_ABS, AXC_HAT_Y, 32'd2);
        send_event(EV_KEY, PAD_BUMPER_R, 32'd0);
    endtask

    task automatic test_ignored_events();
        send_event(5'd31, SYN_REPORT, 32'd1);
        send_event(EV_ABS, 10'h3FF, 32'd77);
        send_event(EV_SYN, 10'd1, 32'd0);
        send_event(EV_SYN, SYN_DROPPED, 32'd0);
    endtask

    task automatic test_dead_zone_limits();
        drain_reports();
        set_dead_zone(8'd0);
        send_event(EV_ABS, AXC_LEFT_X, 32'h81);
        send_event(EV_SYN, SYN_REPORT, 32'd0);
        drain_reports();
        set_dead_zone(8'd128);
        // Sync-dropped clears the report but keeps the dead zone setting.
        send_event(EV_SYN, SYN_DROPPED, 32'd0);
        send_event(EV_ABS, AXC_LEFT_Y, 32'hFF);
        send_event(EV_SYN, SYN_REPORT, 32'd0);
    endtask

    task automatic test_random_traffic();
        logic [7:0] zone;
        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: zone = DEAD_ZONE_RESET;
                1: zone = 8'd0;
                2: zone = 8'd128;
                3: zone = 8'd255;
                4: zone = 8'd1;
                default: zone = 8'($urandom_range(0, 128));
            endcase
            drain_reports();
            set_dead_zone(zone);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (i % 40 == 0)
                begin
                    sender_steady = ($urandom_range(0, 3) == 0);
                    receiver_steady = ($urandom_range(0, 3) == 0);
                end
                deliver_event(pick_event());
            end
        end
        sender_steady = 1'b0;
        receiver_steady = 1'b0;
    endtask

    initial
    begin
        rst_n = 1'b0;
        event_valid = 1'b0;
        event_data = '0;
        cfg_write_en = 1'b0;
        cfg_write_data = '0;
        sender_steady = 1'b0;
        receiver_steady = 1'b0;
        dead_zone = DEAD_ZONE_RESET;
        clear_report_state();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_idle_report();
        test_buttons();
        test_axes();
        test_ignored_events();
        test_dead_zone_limits();
        test_random_traffic();
        drain_reports();

        if (mismatch_count == 0 && pending_reports.size() == 0)
            $display("gamepad_event_to_hid_report regression: pass");
        else
            $display("gamepad_event_to_hid_report regression: fail");
        $finish;
    end

endmodule

>>> sim.f
design/gpad_pkg.sv
design/gpad_in_stage.sv
design/gpad_state.sv
design/gpad_out_stage.sv
design/gamepad_event_to_hid_report.sv
bench/gamepad_event_to_hid_report_test.sv
